/* design/elg_pkg.sv */
// Shared types, constants and the modular shift-add step for the ElGamal unit.
// Depends on nothing; every other design file imports it.
package elg_pkg;

  localparam int VALUE_BITS = 31;
  localparam int CNT_W      = $clog2(VALUE_BITS);

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam val_t MOD_RESET = val_t'(7477);
  localparam val_t GEN_RESET = val_t'(11);
  localparam val_t KEY_RESET = val_t'(13);
  localparam val_t VAL_ONE   = val_t'(1);
  localparam cnt_t CNT_LAST  = cnt_t'(VALUE_BITS - 1);

  typedef enum logic [1:0] {
    CMD_ENC = 2'd0,
    CMD_DEC = 2'd1,
    CMD_CMB = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MOD = 2'd0,
    REG_GEN = 2'd1,
    REG_KEY = 2'd2,
    REG_NONE = 2'd3
  } reg_e;

  // start/done pair of a multi-cycle unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
    val_t res;
  } unit_rsp_t;

  // acc' = (2*acc + b*a) mod p, with acc < p and a < p
  function automatic val_t mm_step(val_t acc, val_t a, logic b, val_t p);
    logic [VALUE_BITS:0] t;
    t = {acc, 1'b0};
    if (t >= {1'b0, p}) t = t - {1'b0, p};
    if (b) t = t + {1'b0, a};
    if (t >= {1'b0, p}) t = t - {1'b0, p};
    return t[VALUE_BITS-1:0];
  endfunction

endpackage

/* design/elgamal_encrypt_decrypt_unit_core.sv */
// ElGamal encrypt / decrypt / ciphertext-combine unit over a modulus p held in
// configuration, with generator and secret exponent; one result item per input
// item, carrying the public key generator^secret mod p unless the modulus is
// below two. All arithmetic runs bit-serially. An item costs one exponentiation
// for the public key plus: encrypt two more exponentiations and a multiply,
// decrypt one exponentiation, an inverse and a multiply, combine four multiplies,
// any other command nothing more. A modulus below two skips all arithmetic and
// returns all zeros. One item is processed at a time; the result register lets
// the next item in while a result waits. Depends on elg_pkg, elg_powmod,
// elg_modinv, elg_modmul.
module elgamal_encrypt_decrypt_unit_core import elg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  val_t       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  val_t       operand_one_i,
  input  val_t       operand_two_i,
  input  val_t       operand_three_i,
  input  val_t       operand_four_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output val_t       first_value_o,
  output val_t       second_value_o,
  output val_t       public_key_o
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_BETA = 13'b0000000000010,
    S_ER1  = 13'b0000000000100,
    S_ER2  = 13'b0000000001000,
    S_EM   = 13'b0000000010000,
    S_DS   = 13'b0000000100000,
    S_DI   = 13'b0000001000000,
    S_DM   = 13'b0000010000000,
    S_CR1  = 13'b0000100000000,
    S_CM1  = 13'b0001000000000,
    S_CR2  = 13'b0010000000000,
    S_CM2  = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_e;

  state_e    state_q;
  logic      go_q;
  logic      out_valid_q;
  val_t      mod_q, gen_q, key_q;
  cmd_e      cmd_q;
  val_t      op1_q, op2_q, op3_q, op4_q;
  val_t      first_q, second_q, beta_q, tmp_q;
  val_t      first_o_q, second_o_q, beta_o_q;
  val_t      pw_base, pw_exp, mm_a, mm_y;
  logic      pw_state, mm_state;
  unit_req_t pw_req, mm_req, inv_req;
  unit_rsp_t pw_rsp, mm_rsp, inv_rsp;
  logic      in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign first_value_o  = first_o_q;
  assign second_value_o = second_o_q;
  assign public_key_o   = beta_o_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MOD_RESET;
      gen_q <= GEN_RESET;
      key_q <= KEY_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_MOD: mod_q <= cfg_wdata_i;
        REG_GEN: gen_q <= cfg_wdata_i;
        REG_KEY: key_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pw_state = 1'b0;
    mm_state = 1'b0;
    pw_base  = gen_q;
    pw_exp   = key_q;
    mm_a     = tmp_q;
    mm_y     = op1_q;
    unique case (state_q)
      S_BETA: pw_state = 1'b1;
      S_ER1: begin
        pw_state = 1'b1;
        pw_exp   = op2_q;
      end
      S_ER2: begin
        pw_state = 1'b1;
        pw_base  = beta_q;
        pw_exp   = op2_q;
      end
      S_DS: begin
        pw_state = 1'b1;
        pw_base  = op1_q;
      end
      S_EM: mm_state = 1'b1;
      S_DM: begin
        mm_state = 1'b1;
        mm_y     = op2_q;
      end
      S_CR1: begin
        mm_state = 1'b1;
        mm_a     = VAL_ONE;
      end
      S_CM1: begin
        mm_state = 1'b1;
        mm_y     = op3_q;
      end
      S_CR2: begin
        mm_state = 1'b1;
        mm_a     = VAL_ONE;
        mm_y     = op2_q;
      end
      S_CM2: begin
        mm_state = 1'b1;
        mm_y     = op4_q;
      end
      default: ;
    endcase
  end

  assign pw_req.start  = go_q && pw_state;
  assign mm_req.start  = go_q && mm_state;
  assign inv_req.start = go_q && (state_q == S_DI);

  elg_powmod u_pw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pw_req),
    .base_i (pw_base),
    .exp_i  (pw_exp),
    .p_i    (mod_q),
    .rsp_o  (pw_rsp)
  );

  elg_modinv u_inv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (inv_req),
    .v_i    (tmp_q),
    .p_i    (mod_q),
    .rsp_o  (inv_rsp)
  );

  elg_modmul u_mm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .a_i    (mm_a),
    .y_i    (mm_y),
    .p_i    (mod_q),
    .rsp_o  (mm_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      go_q <= 1'b0;
      if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (mod_q < val_t'(2)) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_BETA;
              go_q    <= 1'b1;
            end
          end
        end
        S_BETA: begin
          if (pw_rsp.done) begin
            go_q <= 1'b1;
            unique case (cmd_q)
              CMD_ENC: state_q <= S_ER1;
              CMD_DEC: state_q <= S_DS;
              CMD_CMB: state_q <= S_CR1;
              default: begin
                state_q <= S_FIN;
                go_q    <= 1'b0;
              end
            endcase
          end
        end
        S_ER1: if (pw_rsp.done) begin state_q <= S_ER2; go_q <= 1'b1; end
        S_ER2: if (pw_rsp.done) begin state_q <= S_EM;  go_q <= 1'b1; end
        S_EM:  if (mm_rsp.done) state_q <= S_FIN;
        S_DS:  if (pw_rsp.done) begin state_q <= S_DI;  go_q <= 1'b1; end
        S_DI:  if (inv_rsp.done) begin state_q <= S_DM; go_q <= 1'b1; end
        S_DM:  if (mm_rsp.done) state_q <= S_FIN;
        S_CR1: if (mm_rsp.done) begin state_q <= S_CM1; go_q <= 1'b1; end
        S_CM1: if (mm_rsp.done) begin state_q <= S_CR2; go_q <= 1'b1; end
        S_CR2: if (mm_rsp.done) begin state_q <= S_CM2; go_q <= 1'b1; end
        S_CM2: if (mm_rsp.done) state_q <= S_FIN;
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= cmd_e'(command_i);
      op1_q    <= operand_one_i;
      op2_q    <= operand_two_i;
      op3_q    <= operand_three_i;
      op4_q    <= operand_four_i;
      first_q  <= '0;
      second_q <= '0;
      beta_q   <= '0;
    end
    unique case (state_q)
      S_BETA: if (pw_rsp.done) beta_q <= pw_rsp.res;
      S_ER1:  if (pw_rsp.done) first_q <= pw_rsp.res;
      S_ER2:  if (pw_rsp.done) tmp_q <= pw_rsp.res;
      S_EM:   if (mm_rsp.done) second_q <= mm_rsp.res;
      S_DS:   if (pw_rsp.done) tmp_q <= pw_rsp.res;
      S_DI:   if (inv_rsp.done) tmp_q <= inv_rsp.res;
      S_DM:   if (mm_rsp.done) first_q <= mm_rsp.res;
      S_CR1:  if (mm_rsp.done) tmp_q <= mm_rsp.res;
      S_CM1:  if (mm_rsp.done) first_q <= mm_rsp.res;
      S_CR2:  if (mm_rsp.done) tmp_q <= mm_rsp.res;
      S_CM2:  if (mm_rsp.done) second_q <= mm_rsp.res;
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          first_o_q  <= first_q;
          second_o_q <= second_q;
          beta_o_q   <= beta_q;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_idle_no_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !go_q) else $error("unit start while idle");
  a_mm_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rsp.done |-> mm_state) else $error("multiplier done outside a multiply step");
  a_pw_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pw_rsp.done |-> pw_state) else $error("exponentiation done outside its step");
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("finished item not presented");
`endif

endmodule

/* design/elg_modmul.sv */
// Bit-serial modular multiplier: (a * y) mod p, one bit of y per cycle, MSB first.
// Needs a < p. Depends on elg_pkg.
module elg_modmul import elg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  input  val_t      a_i,
  input  val_t      y_i,
  input  val_t      p_i,
  output unit_rsp_t rsp_o
);

  val_t acc_q;
  val_t y_q;
  cnt_t cnt_q;
  logic busy_q;
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + cnt_t'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      y_q   <= y_i;
    end else if (busy_q) begin
      acc_q <= mm_step(acc_q, a_i, y_q[VALUE_BITS-1], p_i);
      y_q   <= {y_q[VALUE_BITS-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

endmodule

/* design/elg_powmod.sv */
// Modular exponentiation base^e mod p, square and multiply MSB first over the
// bit-serial multiplier. Depends on elg_pkg and elg_modmul.
module elg_powmod import elg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  input  val_t      base_i,
  input  val_t      exp_i,
  input  val_t      p_i,
  output unit_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RED  = 4'b0010,
    S_SQ   = 4'b0100,
    S_MUL  = 4'b1000
  } state_e;

  state_e    state_q;
  logic      go_q;
  logic      done_q;
  cnt_t      cnt_q;
  val_t      exp_q;
  val_t      base_q;
  val_t      b_q;
  val_t      acc_q;
  val_t      mm_a;
  val_t      mm_y;
  unit_req_t mm_req;
  unit_rsp_t mm_rsp;
  logic      last;

  assign mm_req.start = go_q;
  assign last         = (cnt_q == CNT_LAST);

  always_comb begin
    unique case (state_q)
      S_RED: begin
        mm_a = VAL_ONE;
        mm_y = base_q;
      end
      S_MUL: begin
        mm_a = b_q;
        mm_y = acc_q;
      end
      default: begin
        mm_a = acc_q;
        mm_y = acc_q;
      end
    endcase
  end

  elg_modmul u_mm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .a_i    (mm_a),
    .y_i    (mm_y),
    .p_i    (p_i),
    .rsp_o  (mm_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go_q    <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      go_q   <= 1'b0;
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            state_q <= S_RED;
            go_q    <= 1'b1;
            cnt_q   <= '0;
          end
        end
        S_RED: begin
          if (mm_rsp.done) begin
            state_q <= S_SQ;
            go_q    <= 1'b1;
          end
        end
        S_SQ: begin
          if (mm_rsp.done) begin
            if (exp_q[VALUE_BITS-1]) begin
              state_q <= S_MUL;
              go_q    <= 1'b1;
            end else if (last) begin
              state_q <= S_IDLE;
              done_q  <= 1'b1;
            end else begin
              cnt_q <= cnt_q + cnt_t'(1);
              go_q  <= 1'b1;
            end
          end
        end
        S_MUL: begin
          if (mm_rsp.done) begin
            if (last) begin
              state_q <= S_IDLE;
              done_q  <= 1'b1;
            end else begin
              state_q <= S_SQ;
              cnt_q   <= cnt_q + cnt_t'(1);
              go_q    <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.start) begin
      exp_q  <= exp_i;
      base_q <= base_i;
      acc_q  <= VAL_ONE;
    end else if (mm_rsp.done) begin
      if (state_q == S_RED) begin
        b_q <= mm_rsp.res;
      end else begin
        acc_q <= mm_rsp.res;
        if (state_q == S_MUL || !exp_q[VALUE_BITS-1]) begin
          exp_q <= {exp_q[VALUE_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

endmodule

/* design/elg_modinv.sv */
// Modular inverse by extended Euclid, one quotient bit per cycle with the
// cofactor kept mod p; gives 0 when no inverse exists. Needs v < p. Depends on elg_pkg.
module elg_modinv import elg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  input  val_t      v_i,
  input  val_t      p_i,
  output unit_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CHK  = 4'b0010,
    S_DIV  = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

  state_e              state_q;
  logic                done_q;
  cnt_t                cnt_q;
  val_t                rp_q;
  val_t                rc_q;
  val_t                tp_q;
  val_t                tc_q;
  val_t                d_q;
  val_t                rem_q;
  val_t                qt_q;
  val_t                res_q;
  logic [VALUE_BITS:0] rem2;
  logic                qbit;
  val_t                t_next;

  assign rem2   = {rem_q, d_q[VALUE_BITS-1]};
  assign qbit   = (rem2 >= {1'b0, rc_q});
  assign t_next = (tp_q >= qt_q) ? (tp_q - qt_q) : (tp_q + (p_i - qt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (req_i.start) state_q <= S_CHK;
        S_CHK: begin
          if (rc_q == '0) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end else begin
            state_q <= S_DIV;
            cnt_q   <= '0;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + cnt_t'(1);
          if (cnt_q == CNT_LAST) state_q <= S_UPD;
        end
        S_UPD: state_q <= S_CHK;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        rp_q <= p_i;
        rc_q <= v_i;
        tp_q <= '0;
        tc_q <= VAL_ONE;
      end
      S_CHK: begin
        d_q   <= rp_q;
        rem_q <= '0;
        qt_q  <= '0;
        res_q <= (rp_q == VAL_ONE) ? tp_q : '0;
      end
      S_DIV: begin
        rem_q <= qbit ? val_t'(rem2 - {1'b0, rc_q}) : rem2[VALUE_BITS-1:0];
        d_q   <= {d_q[VALUE_BITS-2:0], 1'b0};
        qt_q  <= mm_step(qt_q, tc_q, qbit, p_i);
      end
      S_UPD: begin
        rp_q <= rc_q;
        rc_q <= rem_q;
        tp_q <= tc_q;
        tc_q <= t_next;
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

/* tb/tb_elgamal_encrypt_decrypt_unit_core.sv */
// Self-checking testbench for the ElGamal encrypt/decrypt/combine unit.
// Directed table and cases, then random items, checked against known results or an in-bench ElGamal predictor.
// Depends on elg_pkg and elgamal_encrypt_decrypt_unit_core.
module tb_elgamal_encrypt_decrypt_unit_core import elg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    val_t fv;
    val_t sv;
    val_t pk;
  } elg_res_t;

  typedef struct {
    cmd_e     cmd;
    val_t     a;
    val_t     b;
    val_t     c;
    val_t     d;
    logic     known;
    elg_res_t res;
  } dir_row_t;

  logic       clk_i, rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  val_t       cfg_wdata_i;
  logic       in_valid_i, in_ready_o;
  logic [1:0] command_i;
  val_t       operand_one_i, operand_two_i, operand_three_i, operand_four_i;
  logic       out_valid_o, out_ready_i;
  val_t       first_value_o, second_value_o, public_key_o;

  elgamal_encrypt_decrypt_unit_core i_dut (.*);

  longint unsigned mod_q, gen_q, key_q;
  elg_res_t expected_res_q[$];
  int  n_err;
  bit  stim_done;
  int  in_idle_pct, out_idle_pct;
  bit  hold_out;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("tb_elgamal_encrypt_decrypt_unit_core NOT OK");
    $finish;
  end

  function automatic longint unsigned pow_m(longint unsigned x, longint unsigned e,
                                            longint unsigned p);
    longint unsigned acc, bb;
    acc = 1 % p;
    bb  = x % p;
    while (e != 0) begin
      if (e[0]) acc = (acc * bb) % p;
      bb = (bb * bb) % p;
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic longint unsigned inv_m(longint unsigned v, longint unsigned p);
    longint rp, rc, tp, tc, q, rn, tn;
    rp = p;
    rc = v % p;
    tp = 0;
    tc = 1;
    while (rc > 0) begin
      q  = rp / rc;
      rn = rp - q * rc;
      tn = tp - q * tc;
      rp = rc; rc = rn; tp = tc; tc = tn;
    end
    if (rp != 1) return 0;
    if (tp < 0) tp += p;
    return longint'(tp) % p;
  endfunction

  function automatic elg_res_t elgamal_predict(logic [1:0] cmd, val_t a, val_t b,
                                               val_t c, val_t d);
    elg_res_t r;
    longint unsigned p, beta;
    r = '0;
    p = mod_q;
    if (p >= 2) begin
      beta = pow_m(gen_q, key_q, p);
      r.pk = val_t'(beta);
      case (cmd)
        CMD_ENC: begin
          r.fv = val_t'(pow_m(gen_q, b, p));
          r.sv = val_t'(((a % p) * pow_m(beta, b, p)) % p);
        end
        CMD_DEC: r.fv = val_t'(((b % p) * inv_m(pow_m(a, key_q, p), p)) % p);
        CMD_CMB: begin
          r.fv = val_t'(((a % p) * (c % p)) % p);
          r.sv = val_t'(((b % p) * (d % p)) % p);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic write_reg(reg_e idx, val_t v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_MOD: mod_q = v;
      REG_GEN: gen_q = v;
      REG_KEY: key_q = v;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_item(logic [1:0] cmd, val_t a, val_t b, val_t c, val_t d,
                           logic known, elg_res_t res);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    operand_one_i   <= a;
    operand_two_i   <= b;
    operand_three_i <= c;
    operand_four_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    expected_res_q.push_back(known ? res : elgamal_predict(cmd, a, b, c, d));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_res_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic val_t rnd_val(int mode);
    case (mode)
      0: return val_t'($urandom_range(mod_q > 1 ? mod_q - 1 : 0));
      1: return val_t'($urandom);
      2: return val_t'($urandom_range(40));
      default: return val_t'($urandom_range(1, 3) == 1 ? '1 : 0);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_res_q.size() == 0) begin
        $error("unexpected item fv=%0d sv=%0d pk=%0d", first_value_o,
               second_value_o, public_key_o);
        n_err++;
      end else begin
        elg_res_t e;
        e = expected_res_q.pop_front();
        if (first_value_o !== e.fv) begin
          $error("first_value exp %0d got %0d", e.fv, first_value_o); n_err++;
        end
        if (second_value_o !== e.sv) begin
          $error("second_value exp %0d got %0d", e.sv, second_value_o); n_err++;
        end
        if (public_key_o !== e.pk) begin
          $error("public_key exp %0d got %0d", e.pk, public_key_o); n_err++;
        end
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_ready_i <= 1'b0;
        repeat (8000) @(posedge clk_i);
        hold_out = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    elg_res_t z;
    int mode;
    logic [1:0] cmd;
    val_t mods[6];
    n_err = 0;
    hold_out = 1'b0;
    in_idle_pct = 22;
    out_idle_pct = 22;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = REG_MOD; cfg_wdata_i = '0;
    in_valid_i = 1'b0; command_i = CMD_ENC;
    operand_one_i = '0; operand_two_i = '0; operand_three_i = '0; operand_four_i = '0;
    mod_q = 7477; gen_q = 11; key_q = 13;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    z = '0;
    dir_tab = '{
      '{CMD_ENC, 0, 0, 0, 0, 1'b1, '{1, 0, val_t'(pow_m(11, 13, 7477))}},
      '{CMD_ENC, 5, 0, 0, 0, 1'b1, '{1, 5, val_t'(pow_m(11, 13, 7477))}},
      '{CMD_ENC, '1, '1, '1, '1, 1'b0, z},
      '{CMD_ENC, 1234, 77, 0, 0, 1'b0, z},
      '{CMD_DEC, 0, 500, 0, 0, 1'b1, '{0, 0, val_t'(pow_m(11, 13, 7477))}},
      '{CMD_DEC, 7477, 1, 0, 0, 1'b1, '{0, 0, val_t'(pow_m(11, 13, 7477))}},
      '{CMD_DEC, 1, 99, 0, 0, 1'b1, '{99, 0, val_t'(pow_m(11, 13, 7477))}},
      '{CMD_DEC, '1, '1, 0, 0, 1'b0, z},
      '{CMD_DEC, 321, 4000, 0, 0, 1'b0, z},
      '{CMD_CMB, 0, 0, 0, 0, 1'b1, '{0, 0, val_t'(pow_m(11, 13, 7477))}},
      '{CMD_CMB, '1, '1, '1, '1, 1'b0, z},
      '{CMD_CMB, 7478, 2, 3, 7476, 1'b0, z},
      '{CMD_NOP, '1, '1, '1, '1, 1'b1, '{0, 0, val_t'(pow_m(11, 13, 7477))}},
      '{CMD_NOP, 0, 0, 0, 0, 1'b1, '{0, 0, val_t'(pow_m(11, 13, 7477))}}
    };
    foreach (dir_tab[i])
      send_item(dir_tab[i].cmd, dir_tab[i].a, dir_tab[i].b, dir_tab[i].c, dir_tab[i].d,
                dir_tab[i].known, dir_tab[i].res);
    drain();

    // degenerate moduli: everything reads zero
    write_reg(REG_MOD, 0);
    send_item(CMD_ENC, 3, 4, 0, 0, 1'b1, z);
    send_item(CMD_DEC, '1, '1, '1, '1, 1'b1, z);
    drain();
    write_reg(REG_MOD, 1);
    send_item(CMD_CMB, 3, 4, 5, 6, 1'b1, z);
    send_item(CMD_NOP, 3, 4, 5, 6, 1'b1, z);
    drain();

    // zero key, extreme generator
    write_reg(REG_MOD, '1);
    write_reg(REG_GEN, val_t'(2147483646));
    write_reg(REG_KEY, 0);
    send_item(CMD_ENC, 9, 0, 0, 0, 1'b1, '{1, 9, 1});
    send_item(CMD_DEC, '1, 42, 0, 0, 1'b1, '{42, 0, 1});
    drain();
    write_reg(REG_KEY, '1);
    write_reg(REG_GEN, 1);
    send_item(CMD_ENC, '1, '1, '1, '1, 1'b0, z);
    drain();

    mods = '{val_t'(2), val_t'(7477), val_t'(65521), val_t'(2147483647),
             val_t'(12), val_t'(1000003)};
    for (int ph = 0; ph < 11; ph++) begin
      write_reg(REG_MOD, mods[ph % 6]);
      write_reg(REG_GEN, val_t'($urandom_range(1, 2147483646)));
      write_reg(REG_KEY, (ph % 3 == 0) ? val_t'($urandom_range(30)) : val_t'($urandom));
      in_idle_pct = (ph == 4) ? 0 : 22;
      out_idle_pct = (ph == 4) ? 0 : 22;
      if (ph == 2) hold_out = 1'b1;
      for (int k = 0; k < 100; k++) begin
        mode = $urandom_range(3);
        cmd = $urandom_range(99) < 3 ? CMD_NOP : 2'($urandom_range(2));
        // long nonces are slow: mostly short ones
        send_item(cmd, rnd_val(mode),
                  (cmd == CMD_ENC && $urandom_range(9) != 0) ? val_t'($urandom_range(255))
                                                             : rnd_val(mode),
                  rnd_val($urandom_range(3)), rnd_val($urandom_range(3)), 1'b0, z);
      end
      drain();
    end

    if (n_err == 0) begin
      $display("tb_elgamal_encrypt_decrypt_unit_core OK");
    end else begin
      $display("tb_elgamal_encrypt_decrypt_unit_core NOT OK");
    end
    $finish;
  end
endmodule
